// ----- design/tga_rle_pkg.sv -----
// shared types, constants and register codes of the tga rle pixel decoder
`default_nettype none

package tga_rle_pkg;

    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    localparam int POS_W    = 16;
    localparam int REM_W    = 2 * POS_W;
    localparam int PIX_W    = 4 * BYTE_W;
    localparam int COUNT_W  = 8;
    localparam int REP_W    = 7;
    localparam int BIP_W    = 2;
    localparam int STAT_W   = 2;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // opcodes on the byte channel
    localparam logic [OP_W-1:0] OP_IDLE    = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // register indexes on the configuration channel
    localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_HAS_ALPHA = 3'd2;
    localparam logic [IDX_W-1:0] REG_RLE_MODE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TOP_DOWN  = 3'd4;

    // status codes of a result word
    localparam logic [STAT_W-1:0] STAT_DECODING = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERROR    = 2'd2;

    localparam int                 RUN_FLAG_BIT = 7;
    localparam logic [BYTE_W-1:0]  COUNT_MASK   = 8'h7F;
    localparam logic [BYTE_W-1:0]  ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        CLS_IDLE,
        CLS_DATA,
        CLS_RESTART
    } item_cls_t;

    typedef struct packed {
        item_cls_t          cls;
        logic [BYTE_W-1:0]  data;
    } item_t;

    typedef struct packed {
        logic               start;
        logic [POS_W-1:0]   width;
        logic [POS_W-1:0]   height;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
    } rc_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [REM_W-1:0]   total;
        logic [REM_W-1:0]   rem;
    } rc_rsp_t;

endpackage

`default_nettype wire

// ----- design/tga_rle_in_if.sv -----
// byte channel: opcode and data byte with valid/ready
`default_nettype none

interface tga_rle_in_if;
    import tga_rle_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [BYTE_W-1:0]  data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- design/tga_rle_out_if.sv -----
// pixel channel: decoded result word with valid/ready
`default_nettype none

interface tga_rle_out_if;
    import tga_rle_pkg::*;

    logic               valid;
    logic               ready;
    logic               byte_taken;
    logic               pixel_valid;
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic [BYTE_W-1:0]  alpha;
    logic [POS_W-1:0]   dest_x;
    logic [POS_W-1:0]   dest_y;
    logic               last_pixel;
    logic [STAT_W-1:0]  status;

    modport source (
        output valid, output byte_taken, output pixel_valid,
        output red, output green, output blue, output alpha,
        output dest_x, output dest_y, output last_pixel, output status,
        input  ready
    );
    modport sink (
        input  valid, input byte_taken, input pixel_valid,
        input  red, input green, input blue, input alpha,
        input  dest_x, input dest_y, input last_pixel, input status,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/tga_rle_cfg_if.sv -----
// configuration write channel: register index and data with valid/ready
`default_nettype none

interface tga_rle_cfg_if;
    import tga_rle_pkg::*;

    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   index;
    logic [CFG_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/tga_rle_front.sv -----
// front end: accepts byte channel words and classifies the opcode
`default_nettype none

module tga_rle_front (
    tga_rle_in_if.sink          byte_stream,
    input  wire logic           queue_full,
    output tga_rle_pkg::item_t  push_item,
    output logic                push
);
    import tga_rle_pkg::*;

    assign byte_stream.ready = !queue_full;
    assign push              = byte_stream.valid && !queue_full;

    always_comb
    begin
        push_item.data = byte_stream.data_byte;
        unique case (byte_stream.opcode)
            OP_DATA:    push_item.cls = CLS_DATA;
            OP_RESTART: push_item.cls = CLS_RESTART;
            default:    push_item.cls = CLS_IDLE;   // idle tick and the unused code
        endcase
    end

endmodule

`default_nettype wire

// ----- design/tga_rle_queue.sv -----
// short queue of classified words between front and back
`default_nettype none

module tga_rle_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  tga_rle_pkg::item_t       push_item,
    input  wire logic                pop,
    output tga_rle_pkg::item_t       head_item,
    output logic                     not_empty,
    output logic                     full
);
    import tga_rle_pkg::*;

    item_t               entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/tga_rle_remcalc.sv -----
// sequencer that rebuilds image size and pixels left with one shared multiplier
`default_nettype none

module tga_rle_remcalc (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  tga_rle_pkg::rc_req_t    req,
    output tga_rle_pkg::rc_rsp_t    rsp
);
    import tga_rle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOTAL,
        S_ROW,
        S_IDX,
        S_SUB
    } step_t;

    step_t             step_reg;
    logic [REM_W-1:0]  prod_reg;
    logic [REM_W-1:0]  total_reg;
    logic [REM_W-1:0]  idx_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              done_reg;
    logic [POS_W-1:0]  mul_b;

    assign mul_b = (step_reg == S_TOTAL) ? req.height : req.row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= S_IDLE;
            done_reg  <= 1'b0;
            total_reg <= REM_W'(1);
            rem_reg   <= REM_W'(1);
            prod_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            prod_reg <= REM_W'(req.width) * REM_W'(mul_b);
            if (req.start)
            begin
                step_reg <= S_TOTAL;
            end
            else
            begin
                unique case (step_reg)
                    S_IDLE:
                    begin
                        step_reg <= S_IDLE;
                    end
                    S_TOTAL:
                    begin
                        step_reg <= S_ROW;
                    end
                    S_ROW:
                    begin
                        total_reg <= prod_reg;
                        step_reg  <= S_IDX;
                    end
                    S_IDX:
                    begin
                        idx_reg  <= prod_reg + REM_W'(req.col);
                        step_reg <= S_SUB;
                    end
                    S_SUB:
                    begin
                        rem_reg  <= (idx_reg < total_reg) ? total_reg - idx_reg : '0;
                        done_reg <= 1'b1;
                        step_reg <= S_IDLE;
                    end
                    default:
                    begin
                        step_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign rsp.busy  = (step_reg != S_IDLE) || done_reg;
    assign rsp.done  = done_reg;
    assign rsp.total = total_reg;
    assign rsp.rem   = rem_reg;

endmodule

`default_nettype wire

// ----- design/tga_rle_back.sv -----
// back end: configuration registers, packet state machine and result register
`default_nettype none

module tga_rle_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    tga_rle_cfg_if.sink             cfg,
    input  tga_rle_pkg::item_t      head_item,
    input  wire logic               head_valid,
    output logic                    pop,
    output tga_rle_pkg::rc_req_t    rc_req,
    input  tga_rle_pkg::rc_rsp_t    rc_rsp,
    tga_rle_out_if.source           pixel_stream
);
    import tga_rle_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_DONE,
        PH_ERROR
    } phase_t;

    // configuration
    logic [POS_W-1:0]    width_reg;
    logic [POS_W-1:0]    height_reg;
    logic                has_alpha_reg;
    logic                rle_mode_reg;
    logic                top_down_reg;
    logic                cfg_write;
    logic                cfg_size_write;

    // decoder state
    phase_t              phase_reg,  phase_next;
    logic                is_run_reg, is_run_next;
    logic [COUNT_W-1:0]  left_reg,   left_next;
    logic [BIP_W-1:0]    bip_reg,    bip_next;
    logic [PIX_W-1:0]    pix_reg,    pix_next;
    logic [REP_W-1:0]    rep_reg,    rep_next;
    logic [POS_W-1:0]    col_reg,    col_next;
    logic [POS_W-1:0]    row_reg,    row_next;
    logic [REM_W-1:0]    rem_reg,    rem_next;

    // result word
    logic                out_valid_reg;
    logic                taken_reg,  taken_next;
    logic                pvalid_reg, pvalid_next;
    logic [BYTE_W-1:0]   red_reg,    red_next;
    logic [BYTE_W-1:0]   green_reg,  green_next;
    logic [BYTE_W-1:0]   blue_reg,   blue_next;
    logic [BYTE_W-1:0]   alpha_reg,  alpha_next;
    logic [POS_W-1:0]    dx_reg,     dx_next;
    logic [POS_W-1:0]    dy_reg,     dy_next;
    logic                last_reg,   last_next;
    logic [STAT_W-1:0]   status_reg, status_next;

    logic                emit;
    logic                need_rc;
    logic [COUNT_W-1:0]  pkt_count;
    logic [COUNT_W-1:0]  left_dec;
    logic [POS_W-1:0]    col_inc;

    assign cfg.ready      = 1'b1;
    assign cfg_write      = cfg.valid;
    assign cfg_size_write = cfg_write && (cfg.index == REG_WIDTH || cfg.index == REG_HEIGHT);

    assign pop = head_valid && !rc_rsp.busy && (!out_valid_reg || pixel_stream.ready);

    always_comb
    begin
        phase_next  = phase_reg;
        is_run_next = is_run_reg;
        left_next   = left_reg;
        bip_next    = bip_reg;
        pix_next    = pix_reg;
        rep_next    = rep_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        rem_next    = rem_reg;
        taken_next  = 1'b0;
        pvalid_next = 1'b0;
        red_next    = '0;
        green_next  = '0;
        blue_next   = '0;
        alpha_next  = '0;
        dx_next     = '0;
        dy_next     = '0;
        last_next   = 1'b0;
        emit        = 1'b0;
        need_rc     = 1'b0;
        pkt_count   = (head_item.data & COUNT_MASK) + COUNT_W'(1);
        left_dec    = (left_reg != '0) ? left_reg - COUNT_W'(1) : '0;
        col_inc     = col_reg + POS_W'(1);

        if (head_item.cls == CLS_RESTART)
        begin
            phase_next  = PH_HEADER;
            is_run_next = 1'b0;
            left_next   = '0;
            bip_next    = '0;
            pix_next    = '0;
            rep_next    = '0;
            col_next    = '0;
            row_next    = '0;
            rem_next    = rc_rsp.total;
        end
        else
        begin
            // nothing left to place: image counts as complete
            if ((phase_next == PH_HEADER || phase_next == PH_PIXEL) && rem_reg == '0)
            begin
                phase_next = PH_DONE;
                rep_next   = '0;
            end

            if ((phase_next == PH_HEADER || phase_next == PH_PIXEL) && rep_next != '0)
            begin
                // pending run repeat goes out before any new byte
                rep_next = rep_next - REP_W'(1);
                emit     = 1'b1;
            end
            else if (head_item.cls == CLS_DATA &&
                     (phase_next == PH_HEADER || phase_next == PH_PIXEL))
            begin
                taken_next = 1'b1;
                if (rle_mode_reg && phase_next == PH_HEADER)
                begin
                    if (REM_W'(pkt_count) > rem_reg)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        is_run_next = head_item.data[RUN_FLAG_BIT];
                        left_next   = pkt_count;
                        bip_next    = '0;
                        phase_next  = PH_PIXEL;
                    end
                end
                else
                begin
                    phase_next = PH_PIXEL;
                    pix_next[{bip_reg, 3'b000} +: BYTE_W] = head_item.data;
                    if (bip_reg == 2'd3 || (bip_reg == 2'd2 && !has_alpha_reg))
                    begin
                        bip_next = '0;
                        if (rle_mode_reg)
                        begin
                            if (is_run_reg)
                            begin
                                rep_next   = left_dec[REP_W-1:0];
                                left_next  = '0;
                                phase_next = PH_HEADER;
                            end
                            else
                            begin
                                left_next = left_dec;
                                if (left_dec == '0)
                                begin
                                    phase_next = PH_HEADER;
                                end
                            end
                        end
                        emit = 1'b1;
                    end
                    else
                    begin
                        bip_next = bip_reg + BIP_W'(1);
                    end
                end
            end

            if (emit)
            begin
                pvalid_next = 1'b1;
                red_next    = pix_next[23:16];
                green_next  = pix_next[15:8];
                blue_next   = pix_next[7:0];
                alpha_next  = has_alpha_reg ? pix_next[31:24] : ALPHA_OPAQUE;
                dx_next     = col_reg;
                dy_next     = top_down_reg ? row_reg : height_reg - POS_W'(1) - row_reg;
                last_next   = (rem_reg == REM_W'(1));
                if (rem_reg <= REM_W'(1))
                begin
                    phase_next = PH_DONE;
                    rep_next   = '0;
                end
                else
                begin
                    if (col_inc >= width_reg)
                    begin
                        col_next = '0;
                        row_next = row_reg + POS_W'(1);
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                    // a column beyond the row width breaks the unit step, rebuild
                    if (col_reg < width_reg)
                    begin
                        rem_next = rem_reg - REM_W'(1);
                    end
                    else
                    begin
                        need_rc = 1'b1;
                    end
                end
            end
        end

        if (phase_next == PH_ERROR)
        begin
            status_next = STAT_ERROR;
        end
        else if (phase_next == PH_DONE)
        begin
            status_next = STAT_DONE;
        end
        else
        begin
            status_next = STAT_DECODING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= POS_W'(1);
            height_reg    <= POS_W'(1);
            has_alpha_reg <= 1'b0;
            rle_mode_reg  <= 1'b0;
            top_down_reg  <= 1'b0;
            phase_reg     <= PH_HEADER;
            is_run_reg    <= 1'b0;
            left_reg      <= '0;
            bip_reg       <= '0;
            pix_reg       <= '0;
            rep_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            rem_reg       <= REM_W'(1);
            out_valid_reg <= 1'b0;
            taken_reg     <= 1'b0;
            pvalid_reg    <= 1'b0;
            last_reg      <= 1'b0;
            status_reg    <= STAT_DECODING;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg.index)
                    REG_WIDTH:     width_reg     <= cfg.data;
                    REG_HEIGHT:    height_reg    <= cfg.data;
                    REG_HAS_ALPHA: has_alpha_reg <= cfg.data[0];
                    REG_RLE_MODE:  rle_mode_reg  <= cfg.data[0];
                    REG_TOP_DOWN:  top_down_reg  <= cfg.data[0];
                    default:       ;
                endcase
            end

            if (rc_rsp.done)
            begin
                rem_reg <= rc_rsp.rem;
            end

            if (pop)
            begin
                phase_reg     <= phase_next;
                is_run_reg    <= is_run_next;
                left_reg      <= left_next;
                bip_reg       <= bip_next;
                pix_reg       <= pix_next;
                rep_reg       <= rep_next;
                col_reg       <= col_next;
                row_reg       <= row_next;
                rem_reg       <= rem_next;
                out_valid_reg <= 1'b1;
                taken_reg     <= taken_next;
                pvalid_reg    <= pvalid_next;
                last_reg      <= last_next;
                status_reg    <= status_next;
            end
            else if (pixel_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
        end
    end

    assign rc_req.start  = cfg_size_write || (pop && need_rc);
    assign rc_req.width  = width_reg;
    assign rc_req.height = height_reg;
    assign rc_req.row    = row_reg;
    assign rc_req.col    = col_reg;

    assign pixel_stream.valid       = out_valid_reg;
    assign pixel_stream.byte_taken  = taken_reg;
    assign pixel_stream.pixel_valid = pvalid_reg;
    assign pixel_stream.red         = red_reg;
    assign pixel_stream.green       = green_reg;
    assign pixel_stream.blue        = blue_reg;
    assign pixel_stream.alpha       = alpha_reg;
    assign pixel_stream.dest_x      = dx_reg;
    assign pixel_stream.dest_y      = dy_reg;
    assign pixel_stream.last_pixel  = last_reg;
    assign pixel_stream.status      = status_reg;

    // no word leaves the queue while pixels left is being rebuilt
    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rc_rsp.busy |-> !pop)
        else $error("queue popped during pixel count rebuild");

    // a settled pixel count never exceeds the image size
    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !rc_rsp.busy |-> rem_reg <= rc_rsp.total)
        else $error("pixels left exceeds image size");

    // finished or failed images hold no pending repeats
    a_no_repeat_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE || phase_reg == PH_ERROR) |-> rep_reg == '0)
        else $error("repeats pending after image stopped");

    // the final pixel always reports a complete image
    a_last_means_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pvalid_reg && last_reg) |-> status_reg == STAT_DONE)
        else $error("last pixel without complete status");

endmodule

`default_nettype wire

// ----- design/tga_rle_pixel_decoder.sv -----
// top level of the tga rle pixel decoder: front, queue, back and count rebuild
// a word's result passes through the queue and the back end's result register before it is shown
// throughput: one word per cycle while the pixel channel is ready and no rebuild is running
// a write to width or height, and a pixel placed at a column beyond the row width,
//   holds the back end while the shared multiplier rebuilds pixels left
// reset (rst_n, async, active low): width 1, height 1, bgr, uncompressed, bottom-up, queue empty
`default_nettype none

module tga_rle_pixel_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tga_rle_in_if.sink      byte_stream,
    tga_rle_out_if.source   pixel_stream,
    tga_rle_cfg_if.sink     cfg
);
    import tga_rle_pkg::*;

    // classified words travelling from front to back
    item_t    push_item;
    item_t    head_item;
    logic     push;
    logic     pop;
    logic     queue_full;
    logic     head_valid;

    // pixels-left rebuild handshake
    rc_req_t  rc_req;
    rc_rsp_t  rc_rsp;

    // front end takes a word whenever the queue has room
    tga_rle_front u_front (
        .byte_stream (byte_stream),
        .queue_full  (queue_full),
        .push_item   (push_item),
        .push        (push)
    );

    // short queue lets the front keep accepting while the output stalls
    tga_rle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (head_valid),
        .full      (queue_full)
    );

    // image size and pixels left, rebuilt after a size change or a pixel beyond the row width
    tga_rle_remcalc u_remcalc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rc_req),
        .rsp   (rc_rsp)
    );

    // packet parsing, pixel assembly, position tracking and result register
    tga_rle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_item    (head_item),
        .head_valid   (head_valid),
        .pop          (pop),
        .rc_req       (rc_req),
        .rc_rsp       (rc_rsp),
        .pixel_stream (pixel_stream)
    );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// testbench of the tga rle pixel decoder: directed table, random image streams, own decode model
`timescale 1ns / 100ps

module tb;
    import tga_rle_pkg::*;

    // opcode three has no name in the package, the block treats it as an idle tick
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int TOTAL_WORDS    = 1750;
    localparam int MAX_GAP        = 6;
    localparam int LONG_STALL     = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    // one result word as the pixel channel shows it
    typedef struct packed {
        logic               byte_taken;
        logic               pixel_valid;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic [BYTE_W-1:0]  alpha;
        logic [POS_W-1:0]   dest_x;
        logic [POS_W-1:0]   dest_y;
        logic               last_pixel;
        logic [STAT_W-1:0]  status;
    } pix_res_t;

    localparam pix_res_t QUIET = '0;

    // decoder phase as tracked by the model below
    typedef enum logic [1:0] {
        HDR_WAIT,
        PIX_COLLECT,
        IMG_DONE,
        PKT_ERROR
    } dec_phase_t;

    // rows of the directed table: a byte-channel word or a register write
    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   idx;
        logic [CFG_W-1:0]   value;
        logic               typed;
        pix_res_t           want;
    } stim_row_t;

    logic clk;
    logic rst_n = 1'b0;

    tga_rle_in_if  byte_if ();
    tga_rle_out_if pix_if ();
    tga_rle_cfg_if cfg_if ();

    tga_rle_pixel_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (byte_if),
        .pixel_stream (pix_if),
        .cfg          (cfg_if)
    );

    // registers as the model sees them
    logic [POS_W-1:0]   img_width;
    logic [POS_W-1:0]   img_height;
    logic               img_alpha;
    logic               img_rle;
    logic               img_top_down;

    // decoder state as the model sees it
    dec_phase_t         dec_phase;
    logic               run_packet;
    logic [COUNT_W-1:0] pkt_left;
    logic [BIP_W-1:0]   byte_idx;
    logic [PIX_W-1:0]   held_pixel;
    logic [REP_W-1:0]   run_repeats;
    logic [POS_W-1:0]   src_col;
    logic [POS_W-1:0]   src_row;

    // expected result words, oldest first
    pix_res_t           awaited_words[$];
    stim_row_t          stim_table[$];

    int                 words_sent;
    int                 words_checked;
    int                 failures;
    int                 tx_burst;
    int                 rx_burst;
    int                 idle_cycles;
    logic               last_taken;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // decode model
    // ---------------------------------------------------------------

    function automatic void clear_decoder();
        dec_phase   = HDR_WAIT;
        run_packet  = 1'b0;
        pkt_left    = '0;
        byte_idx    = '0;
        held_pixel  = '0;
        run_repeats = '0;
        src_col     = '0;
        src_row     = '0;
    endfunction

    // pixels of the image still to come, judged against the current registers
    function automatic longint unsigned pixels_left();
        longint unsigned total;
        longint unsigned pos;
        total = 64'(img_width) * 64'(img_height);
        pos   = 64'(src_row) * 64'(img_width) + 64'(src_col);
        return (pos < total) ? total - pos : 64'd0;
    endfunction

    // gives out the held pixel at the current source position and moves on
    function automatic pix_res_t place_pixel();
        pix_res_t        r;
        longint unsigned left;
        left          = pixels_left();
        r             = '0;
        r.pixel_valid = 1'b1;
        r.red         = held_pixel[23:16];
        r.green       = held_pixel[15:8];
        r.blue        = held_pixel[7:0];
        r.alpha       = img_alpha ? held_pixel[31:24] : ALPHA_OPAQUE;
        r.dest_x      = src_col;
        // bottom-up origin flips the row
        r.dest_y      = img_top_down ? src_row : img_height - 16'd1 - src_row;
        r.last_pixel  = (left == 64'd1);
        if (left <= 64'd1)
        begin
            dec_phase   = IMG_DONE;
            run_repeats = '0;
        end
        else
        begin
            src_col = src_col + 1'b1;
            if (src_col >= img_width)
            begin
                src_col = '0;
                src_row = src_row + 1'b1;
            end
        end
        return r;
    endfunction

    // expected result word of one accepted byte-channel word
    function automatic pix_res_t decode_word(input logic [OP_W-1:0] op,
                                             input logic [BYTE_W-1:0] b);
        pix_res_t    r;
        logic [8:0]  count;
        int unsigned bpp;
        r = '0;
        if (op == OP_RESTART)
        begin
            clear_decoder();
        end
        else
        begin
            // registers may have shrunk the image below the current position
            if (dec_phase < IMG_DONE && pixels_left() == 64'd0)
            begin
                dec_phase   = IMG_DONE;
                run_repeats = '0;
            end
            if (dec_phase < IMG_DONE && run_repeats != '0)
            begin
                // pending run: any tick gives the next repeat, the byte waits
                run_repeats = run_repeats - 1'b1;
                r = place_pixel();
            end
            else if (op == OP_DATA && dec_phase < IMG_DONE)
            begin
                if (img_rle && dec_phase == HDR_WAIT)
                begin
                    count = {1'b0, b & COUNT_MASK} + 9'd1;
                    if (64'(count) > pixels_left())
                    begin
                        dec_phase = PKT_ERROR;
                    end
                    else
                    begin
                        run_packet = b[RUN_FLAG_BIT];
                        pkt_left   = count[COUNT_W-1:0];
                        byte_idx   = '0;
                        dec_phase  = PIX_COLLECT;
                    end
                end
                else
                begin
                    bpp       = img_alpha ? 4 : 3;
                    dec_phase = PIX_COLLECT;
                    held_pixel[byte_idx*8 +: 8] = b;
                    if (byte_idx + 1 >= bpp)
                    begin
                        byte_idx = '0;
                        if (img_rle)
                        begin
                            if (run_packet)
                            begin
                                run_repeats = (pkt_left > 0) ? REP_W'(pkt_left - 8'd1) : '0;
                                pkt_left    = '0;
                                dec_phase   = HDR_WAIT;
                            end
                            else
                            begin
                                if (pkt_left > 0)
                                    pkt_left = pkt_left - 1'b1;
                                if (pkt_left == 0)
                                    dec_phase = HDR_WAIT;
                            end
                        end
                        r = place_pixel();
                    end
                    else
                    begin
                        byte_idx = byte_idx + 1'b1;
                    end
                end
                r.byte_taken = 1'b1;
            end
        end
        r.status = (dec_phase == PKT_ERROR) ? STAT_ERROR :
                   (dec_phase == IMG_DONE)  ? STAT_DONE  : STAT_DECODING;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // channel drivers
    // ---------------------------------------------------------------

    // idle cycles before a handshake, with stretches of none at all
    function automatic int draw_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(39, 0) == 0)
        begin
            burst = $urandom_range(60, 15);
            return 0;
        end
        return $urandom_range(MAX_GAP, 0);
    endfunction

    // offers one word on the byte channel and records what it should give
    task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                             input logic typed, input pix_res_t want);
        int       gap;
        pix_res_t predicted;
        gap = draw_gap(tx_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.opcode    <= op;
        byte_if.data_byte <= b;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        predicted  = decode_word(op, b);
        last_taken = predicted.byte_taken;
        // a typed row carries its own expectation, the model still advances
        awaited_words.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    // register write, only once every expected word has come back
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        byte_if.valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_WIDTH:     img_width    = value;
            REG_HEIGHT:    img_height   = value;
            REG_HAS_ALPHA: img_alpha    = value[0];
            REG_RLE_MODE:  img_rle      = value[0];
            REG_TOP_DOWN:  img_top_down = value[0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------

    function automatic pix_res_t no_pixel(input logic taken, input logic [STAT_W-1:0] st);
        pix_res_t r;
        r            = '0;
        r.byte_taken = taken;
        r.status     = st;
        return r;
    endfunction

    function automatic void add_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                                     input logic typed, input pix_res_t want);
        stim_row_t row;
        row.kind  = ROW_WORD;
        row.op    = op;
        row.idx   = '0;
        row.value = CFG_W'(b);
        row.typed = typed;
        row.want  = want;
        stim_table.push_back(row);
    endfunction

    function automatic void add_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        stim_row_t row;
        row.kind  = ROW_REG;
        row.op    = OP_IDLE;
        row.idx   = idx;
        row.value = value;
        row.typed = 1'b0;
        row.want  = QUIET;
        stim_table.push_back(row);
    endfunction

    function automatic void build_table();
        pix_res_t first_px;
        first_px             = no_pixel(1'b1, STAT_DONE);
        first_px.pixel_valid = 1'b1;
        first_px.red         = 8'h80;
        first_px.green       = 8'hFF;
        first_px.blue        = 8'h00;
        first_px.alpha       = ALPHA_OPAQUE;
        first_px.last_pixel  = 1'b1;

        // reset registers: 1x1 image, bgr, uncompressed, bottom-up
        add_word(OP_IDLE,    8'h00, 1'b1, no_pixel(1'b0, STAT_DECODING));
        add_word(OP_DATA,    8'h00, 1'b1, no_pixel(1'b1, STAT_DECODING));
        add_word(OP_DATA,    8'hFF, 1'b1, no_pixel(1'b1, STAT_DECODING));
        add_word(OP_DATA,    8'h80, 1'b1, first_px);
        // image complete: bytes are refused, opcode three idles
        add_word(OP_DATA,    8'h55, 1'b1, no_pixel(1'b0, STAT_DONE));
        add_word(OP_SPARE,   8'hFF, 1'b1, no_pixel(1'b0, STAT_DONE));
        add_word(OP_RESTART, 8'hA5, 1'b1, no_pixel(1'b0, STAT_DECODING));

        // 2x2 bgra, run-length, top-down
        add_reg(REG_WIDTH,     16'd2);
        add_reg(REG_HEIGHT,    16'd2);
        add_reg(REG_HAS_ALPHA, 16'd1);
        add_reg(REG_RLE_MODE,  16'd1);
        add_reg(REG_TOP_DOWN,  16'd1);

        // run of two, second copy given on an idle tick
        add_word(OP_DATA, 8'h81, 1'b0, QUIET);
        add_word(OP_DATA, 8'h11, 1'b0, QUIET);
        add_word(OP_DATA, 8'h22, 1'b0, QUIET);
        add_word(OP_DATA, 8'h33, 1'b0, QUIET);
        add_word(OP_DATA, 8'h44, 1'b0, QUIET);
        add_word(OP_IDLE, 8'h00, 1'b0, QUIET);
        // largest count with two pixels left: packet overflow, sticky
        add_word(OP_DATA,    8'h7F, 1'b1, no_pixel(1'b1, STAT_ERROR));
        add_word(OP_DATA,    8'hAA, 1'b1, no_pixel(1'b0, STAT_ERROR));
        add_word(OP_RESTART, 8'h00, 1'b1, no_pixel(1'b0, STAT_DECODING));

        // raw packet of one all-zero pixel
        add_word(OP_DATA, 8'h00, 1'b0, QUIET);
        add_word(OP_DATA, 8'h00, 1'b0, QUIET);
        add_word(OP_DATA, 8'h00, 1'b0, QUIET);
        add_word(OP_DATA, 8'h00, 1'b0, QUIET);
        add_word(OP_DATA, 8'h00, 1'b0, QUIET);
        // run that exactly fills the rest, byte offered while repeats remain
        add_word(OP_DATA, 8'h82, 1'b0, QUIET);
        add_word(OP_DATA, 8'hFF, 1'b0, QUIET);
        add_word(OP_DATA, 8'hFF, 1'b0, QUIET);
        add_word(OP_DATA, 8'hFF, 1'b0, QUIET);
        add_word(OP_DATA, 8'hFF, 1'b0, QUIET);
        add_word(OP_DATA, 8'h12, 1'b0, QUIET);
        add_word(OP_IDLE, 8'h00, 1'b0, QUIET);
    endfunction

    // ---------------------------------------------------------------
    // random image streams
    // ---------------------------------------------------------------

    // image dimension: mostly tiny, sometimes the extremes
    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(9, 0))
            0:       return 16'hFFFF;
            1:       return CFG_W'($urandom_range(65535, 1));
            2:       return 16'd1;
            default: return CFG_W'($urandom_range(6, 1));
        endcase
    endfunction

    // a byte as a real source sends it: offered again until taken
    task automatic offer_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(15, 0) == 0)
            send_word(OP_IDLE, 8'($urandom), 1'b0, QUIET);
        send_word(OP_DATA, b, 1'b0, QUIET);
        while (!last_taken && dec_phase < IMG_DONE)
            send_word(OP_DATA, b, 1'b0, QUIET);
    endtask

    // one packet in run-length mode, else one pixel
    task automatic send_piece();
        longint unsigned   left;
        int                cap;
        int                n;
        int                reps;
        int                bpp;
        logic              run;
        bpp  = img_alpha ? 4 : 3;
        reps = bpp;
        if (img_rle && dec_phase == HDR_WAIT && run_repeats == '0)
        begin
            left = pixels_left();
            cap  = (left < 64'd128) ? int'(left) : 128;
            if (cap < 1)
                cap = 1;
            if (left < 64'd128 && $urandom_range(19, 0) == 0)
                n = $urandom_range(128, int'(left) + 1);   // count past the image end
            else if ($urandom_range(3, 0) == 0)
                n = $urandom_range(cap, 1);
            else
                n = $urandom_range((cap < 4) ? cap : 4, 1);
            run = $urandom_range(1, 0);
            offer_byte({run, 7'(n - 1)});
            reps = run ? bpp : n * bpp;
        end
        for (int i = 0; i < reps; i++)
        begin
            if (dec_phase >= IMG_DONE)
                break;
            offer_byte(8'($urandom));
        end
    endtask

    task automatic random_phase(input logic write_all);
        int budget;
        int phase_start;
        // registers change only with the block idle, sometimes mid-image
        if (write_all || $urandom_range(9, 0) < 7)
            write_reg(REG_WIDTH, pick_dim());
        if (write_all || $urandom_range(9, 0) < 7)
            write_reg(REG_HEIGHT, pick_dim());
        if (write_all || $urandom_range(9, 0) < 7)
            write_reg(REG_HAS_ALPHA, CFG_W'($urandom_range(1, 0)));
        if (write_all || $urandom_range(9, 0) < 7)
            write_reg(REG_RLE_MODE, CFG_W'($urandom_range(9, 0) < 7));
        if (write_all || $urandom_range(9, 0) < 7)
            write_reg(REG_TOP_DOWN, CFG_W'($urandom_range(1, 0)));
        if ($urandom_range(9, 0) != 0)
            send_word(OP_RESTART, 8'($urandom), 1'b0, QUIET);

        budget      = $urandom_range(120, 20);
        phase_start = words_sent;
        while (words_sent - phase_start < budget)
        begin
            if (dec_phase >= IMG_DONE)
            begin
                // finished or broken image: a short tail of refused words
                send_word(OP_DATA, 8'($urandom), 1'b0, QUIET);
                send_word(OP_SPARE, 8'($urandom), 1'b0, QUIET);
                break;
            end
            case ($urandom_range(29, 0))
                0:       send_word(OP_W'($urandom_range(3, 0)), 8'($urandom), 1'b0, QUIET);
                1:       send_word(OP_IDLE, 8'($urandom), 1'b0, QUIET);
                2:       send_word(OP_SPARE, 8'($urandom), 1'b0, QUIET);
                3:
                begin
                    // broken sequence: restart mid-image or a stray byte
                    if ($urandom_range(3, 0) == 0)
                        send_word(OP_RESTART, 8'($urandom), 1'b0, QUIET);
                    else
                        offer_byte(8'($urandom));
                end
                default: send_piece();
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // pixel sink: random ready, two long hold-offs so the block backs up
    initial
    begin : pixel_sink
        int       gap;
        pix_res_t got;
        pix_res_t want;
        pix_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(rx_burst);
            if (words_checked == 500 || words_checked == 1200)
                gap = LONG_STALL;
            @(negedge clk);
            if (gap > 0)
            begin
                pix_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pix_if.ready <= 1'b1;
            @(posedge clk);
            while (!pix_if.valid)
                @(posedge clk);
            got = {pix_if.byte_taken, pix_if.pixel_valid, pix_if.red, pix_if.green,
                   pix_if.blue, pix_if.alpha, pix_if.dest_x, pix_if.dest_y,
                   pix_if.last_pixel, pix_if.status};
            words_checked++;
            if (awaited_words.size() == 0)
            begin
                $error("result word with nothing expected");
                failures++;
            end
            else
            begin
                want = awaited_words.pop_front();
                check_field("byte_taken",  32'(want.byte_taken),  32'(got.byte_taken));
                check_field("pixel_valid", 32'(want.pixel_valid), 32'(got.pixel_valid));
                check_field("red",         32'(want.red),         32'(got.red));
                check_field("green",       32'(want.green),       32'(got.green));
                check_field("blue",        32'(want.blue),        32'(got.blue));
                check_field("alpha",       32'(want.alpha),       32'(got.alpha));
                check_field("dest_x",      32'(want.dest_x),      32'(got.dest_x));
                check_field("dest_y",      32'(want.dest_y),      32'(got.dest_y));
                check_field("last_pixel",  32'(want.last_pixel),  32'(got.last_pixel));
                check_field("status",      32'(want.status),      32'(got.status));
            end
        end
    end

    // watchdog: cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin : main_seq
        byte_if.valid     = 1'b0;
        byte_if.opcode    = OP_IDLE;
        byte_if.data_byte = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = REG_WIDTH;
        cfg_if.data       = '0;
        words_sent        = 0;
        words_checked     = 0;
        failures          = 0;
        tx_burst          = 0;
        rx_burst          = 0;
        idle_cycles       = 0;
        last_taken        = 1'b0;

        // model starts from the reset registers
        img_width    = 16'd1;
        img_height   = 16'd1;
        img_alpha    = 1'b0;
        img_rle      = 1'b0;
        img_top_down = 1'b0;
        clear_decoder();
        build_table();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_REG)
                write_reg(stim_table[i].idx, stim_table[i].value);
            else
                send_word(stim_table[i].op, stim_table[i].value[BYTE_W-1:0],
                          stim_table[i].typed, stim_table[i].want);
        end

        // random image streams, first phase sets every register
        random_phase(1'b1);
        while (words_sent < TOTAL_WORDS)
            random_phase(1'b0);

        @(negedge clk);
        byte_if.valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- tga_rle_pixel_decoder.f -----
design/tga_rle_pkg.sv
design/tga_rle_in_if.sv
design/tga_rle_out_if.sv
design/tga_rle_cfg_if.sv
design/tga_rle_front.sv
design/tga_rle_queue.sv
design/tga_rle_remcalc.sv
design/tga_rle_back.sv
design/tga_rle_pixel_decoder.sv
sim/tb.sv
